// ----- rtl/core/per_id_exec_time_stats_defines.svh -----
// assertion macros for the per-task execution time statistics block
// used by the rtl files that carry concurrent checks; expects clk and rst_n in scope
`ifndef PER_ID_EXEC_TIME_STATS_DEFINES_SVH
`define PER_ID_EXEC_TIME_STATS_DEFINES_SVH

// check that holds outside of reset
`define PETS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that also holds while reset is applied
`define PETS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/pets_pkg.sv -----
// shared types and constants for the per-task execution time statistics block
// no dependencies
package pets_pkg;

  localparam int unsigned US_W    = 24;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned ID_W    = 3;
  localparam int unsigned KIND_W  = 2;

  // serial multiplier operand widths and product
  localparam int unsigned MUL_A_W = US_W;
  localparam int unsigned MUL_B_W = CNT_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned STEP_W  = $clog2(MUL_A_W);

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd4000;

  // transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_RECORD = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [TICK_W-1:0] ticks;
  } pets_in_t;

  typedef struct packed {
    logic              accepted;
    logic [US_W-1:0]   max_us;
    logic [US_W-1:0]   min_us;
    logic [US_W-1:0]   mean_us;
    logic [CNT_W-1:0]  samples;
  } pets_out_t;

  // per-task statistics entry
  typedef struct packed {
    logic [US_W-1:0]  max_us;
    logic [US_W-1:0]  min_us;
    logic [US_W-1:0]  mean_us;
    logic [CNT_W-1:0] samples;
  } pets_entry_t;

  localparam pets_entry_t ENTRY_RESET = '{
    max_us:  '0,
    min_us:  '1,
    mean_us: '0,
    samples: '0
  };

endpackage

// ----- rtl/core/pets_sermul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on pets_pkg
module pets_sermul
  import pets_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  logic [MUL_B_W-1:0] hi_r, hi_nxt;
  logic [MUL_A_W-1:0] lo_r, lo_nxt;
  logic [MUL_B_W-1:0] b_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [MUL_B_W:0]   sum;

  // one partial product per cycle, shifted out at the low end
  always_comb begin
    sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, b_r} : '0);
    hi_nxt = sum[MUL_B_W:1];
    lo_nxt = {sum[0], lo_r[MUL_A_W-1:1]};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(MUL_A_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= a;
      b_r  <= b;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

// ----- rtl/core/pets_serdiv.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit in US_W bits
// depends on pets_pkg
module pets_serdiv
  import pets_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [PROD_W-1:0]  num,
  input  logic [MUL_B_W-1:0] den,
  output logic               done,
  output logic [US_W-1:0]    quot
);

  logic [MUL_B_W-1:0] rem_r, rem_nxt;
  logic [US_W-1:0]    q_r, q_nxt;
  logic [MUL_B_W-1:0] den_r;
  logic [STEP_W-1:0]  step_r;
  logic               busy_r;
  logic               done_r;
  logic [MUL_B_W:0]   trial;
  logic [MUL_B_W+1:0] diff;
  logic               ge;

  // shift in the next numerator bit and try a subtract
  always_comb begin
    trial   = {rem_r, q_r[US_W-1]};
    diff    = {1'b0, trial} - {2'b0, den_r};
    ge      = !diff[MUL_B_W+1];
    rem_nxt = ge ? diff[MUL_B_W-1:0] : trial[MUL_B_W-1:0];
    q_nxt   = {q_r[US_W-2:0], ge};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == STEP_W'(US_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  // datapath: upper numerator bits are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[PROD_W-1:US_W];
      q_r   <= num[US_W-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/core/per_id_exec_time_stats.sv -----
// top level of the per-task execution time statistics block
// depends on pets_pkg, pets_sermul, pets_serdiv and per_id_exec_time_stats_defines.svh
`include "per_id_exec_time_stats_defines.svh"

// Keeps maximum, minimum, integer running mean and a saturating sample count of
// execution time per task. Ticks become microseconds as (ticks * cfg_data) >> 8, the
// scale being written on the cfg port (reset 4000, i.e. 15.625 us per tick). A record
// transaction first reads the table, then runs the tick conversion, the mean times
// count product and the division by count + 1 each through a 24-step bit-serial
// unit, and last writes the table. Queries only read the table; clear and rejected
// transactions go straight to the result. One transaction is worked on at a time;
// the next one is taken while the previous result waits in the output register.
// Statistics live in a NUM_TASKS deep table with a valid bit per entry, so reset and
// clear take effect at once with no clearing pass.
module per_id_exec_time_stats
  import pets_pkg::*;
#(
  parameter int unsigned NUM_TASKS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pets_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pets_out_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_data
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CMP_W = 7;
  localparam logic [CMP_W-1:0] NUM_TASKS_C = CMP_W'(NUM_TASKS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_LOAD  = 7'b0000100,
    S_MUS   = 7'b0001000,
    S_MMEAN = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t               state_r;
  logic [SCALE_W-1:0]   scale_r;
  logic [KIND_W-1:0]    kind_r;
  logic [ID_W-1:0]      id_r;
  logic [TICK_W-1:0]    ticks_r;
  logic [US_W-1:0]      us_r;
  pets_entry_t          ent_r;
  pets_out_t            res_r;
  pets_out_t            out_r;
  logic                 out_valid_r;
  logic [NUM_TASKS-1:0] valid_r;
  logic                 vrd_r;
  pets_entry_t          rd_r;
  pets_entry_t          mem [NUM_TASKS];
  pets_entry_t          cur_ent;
  pets_entry_t          new_ent;
  logic [IDX_W-1:0]     addr;
  logic                 in_acc;
  logic                 in_range;
  logic                 mem_we;
  logic                 mul_start;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_prod;
  logic                 div_start;
  logic [PROD_W-1:0]    div_num;
  logic [MUL_B_W-1:0]   div_den;
  logic                 div_done;
  logic [US_W-1:0]      div_quot;
  logic                 out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_range  = (CMP_W'(in_data.task_id) < NUM_TASKS_C);
  assign addr      = IDX_W'(id_r);
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign mem_we    = (state_r == S_DIV) && div_done;

  // scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  // entry as read, unwritten entries read as reset values
  assign cur_ent = vrd_r ? rd_r : ENTRY_RESET;

  // updated entry once the mean is known
  always_comb begin
    new_ent         = ent_r;
    new_ent.max_us  = (us_r > ent_r.max_us) ? us_r : ent_r.max_us;
    new_ent.min_us  = (us_r < ent_r.min_us) ? us_r : ent_r.min_us;
    new_ent.mean_us = div_quot;
    new_ent.samples = (ent_r.samples == '1) ? ent_r.samples : ent_r.samples + 1'b1;
  end

  // serial unit operands
  always_comb begin
    mul_start = 1'b0;
    mul_a     = ent_r.mean_us;
    mul_b     = {1'b0, ent_r.samples};
    if (state_r == S_LOAD) begin
      mul_start = (kind_r == KIND_RECORD);
      mul_a     = MUL_A_W'(ticks_r);
      mul_b     = MUL_B_W'(scale_r);
    end else if (state_r == S_MUS) begin
      mul_start = mul_done;
    end
  end

  assign div_start = (state_r == S_MMEAN) && mul_done;
  assign div_num   = mul_prod + PROD_W'(us_r);
  assign div_den   = {1'b0, ent_r.samples} + 1'b1;

  pets_sermul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pets_serdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // statistics table
  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rd_r <= mem[addr];
    end
    if (mem_we) begin
      mem[addr] <= new_ent;
    end
  end

  // entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vrd_r   <= 1'b0;
    end else begin
      if (state_r == S_READ) begin
        vrd_r <= valid_r[addr];
      end
      if (in_acc && in_data.kind == KIND_CLEAR) begin
        valid_r <= '0;
      end else if (mem_we) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_data.kind == KIND_CLEAR) begin
              state_r <= S_DONE;
            end else if (in_data.kind == KIND_UNUSED || !in_range) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          state_r <= S_LOAD;
        end
        S_LOAD: begin
          state_r <= (kind_r == KIND_RECORD) ? S_MUS : S_DONE;
        end
        S_MUS: begin
          if (mul_done) begin
            state_r <= S_MMEAN;
          end
        end
        S_MMEAN: begin
          if (mul_done) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // transaction capture and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r  <= in_data.kind;
      id_r    <= in_data.task_id;
      ticks_r <= in_data.ticks;
      if (in_data.kind == KIND_CLEAR) begin
        res_r <= '{accepted: 1'b1, max_us: '0, min_us: '1, mean_us: '0, samples: '0};
      end else begin
        res_r <= '0;
      end
    end
    if (state_r == S_LOAD) begin
      ent_r <= cur_ent;
      res_r <= '{accepted: 1'b1, max_us: cur_ent.max_us, min_us: cur_ent.min_us,
                 mean_us: cur_ent.mean_us, samples: cur_ent.samples};
    end
    if (state_r == S_MUS && mul_done) begin
      us_r <= mul_prod[US_W+7:8];
    end
    if (mem_we) begin
      res_r <= '{accepted: 1'b1, max_us: new_ent.max_us, min_us: new_ent.min_us,
                 mean_us: new_ent.mean_us, samples: new_ent.samples};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `PETS_ASSERT(a_mul_done_state, mul_done |-> (state_r == S_MUS || state_r == S_MMEAN), "multiplier finished outside a multiply step")
  `PETS_ASSERT(a_div_done_state, div_done |-> (state_r == S_DIV), "divider finished outside the divide step")
  `PETS_ASSERT(a_done_drains, (state_r == S_DONE && !out_valid_r) |=> (out_valid_r && state_r == S_IDLE), "finished result not moved to output")
  `PETS_ASSERT(a_clear_all, (in_acc && in_data.kind == KIND_CLEAR) |=> (valid_r == '0), "clear transaction left a valid entry")

endmodule
